>>> hdl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, constants, coefficient table and helpers for the Legendre
// forward recurrence block.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int FRAC_BITS   = 30;
  localparam int MAX_ORDER   = 63;
  localparam int ORD_W       = 6;
  localparam int FIX_W       = 32;
  localparam int PROD_W      = 2 * FIX_W;
  localparam int RND_W       = PROD_W - FRAC_BITS;
  localparam int SUM_W       = RND_W + 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  typedef logic signed [FIX_W-1:0]  fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [ORD_W-1:0]         ord_t;

  localparam fix_t  ONE_FIX     = fix_t'(64'sd1 <<< FRAC_BITS);
  localparam fix_t  NEG_ONE_FIX = -ONE_FIX;
  localparam prod_t ROUND_HALF  = prod_t'(64'sd1 <<< (FRAC_BITS - 1));

  localparam ord_t HIGHEST_ORDER_RESET = ord_t'(50);

  // register word indexes
  typedef enum logic [0:0] {
    REG_HIGHEST_ORDER = 1'b0
  } reg_idx_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EMIT0,
    CMD_EMIT1,
    CMD_MUL_A,
    CMD_RND,
    CMD_MUL_B,
    CMD_MUL_T,
    CMD_NEXT,
    CMD_EMITN
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_last;
    logic lmax_one;
  } dp_status_t;

  // b_l = l/(l+1) rounded; a_l = (2l+1)/(l+1) rounded equals one plus b_l
  localparam fix_t COEF_B [0:MAX_ORDER] = '{
    fix_t'(((64'd0  << FRAC_BITS) + 64'd0)  / 64'd1),
    fix_t'(((64'd1  << FRAC_BITS) + 64'd1)  / 64'd2),
    fix_t'(((64'd2  << FRAC_BITS) + 64'd1)  / 64'd3),
    fix_t'(((64'd3  << FRAC_BITS) + 64'd2)  / 64'd4),
    fix_t'(((64'd4  << FRAC_BITS) + 64'd2)  / 64'd5),
    fix_t'(((64'd5  << FRAC_BITS) + 64'd3)  / 64'd6),
    fix_t'(((64'd6  << FRAC_BITS) + 64'd3)  / 64'd7),
    fix_t'(((64'd7  << FRAC_BITS) + 64'd4)  / 64'd8),
    fix_t'(((64'd8  << FRAC_BITS) + 64'd4)  / 64'd9),
    fix_t'(((64'd9  << FRAC_BITS) + 64'd5)  / 64'd10),
    fix_t'(((64'd10 << FRAC_BITS) + 64'd5)  / 64'd11),
    fix_t'(((64'd11 << FRAC_BITS) + 64'd6)  / 64'd12),
    fix_t'(((64'd12 << FRAC_BITS) + 64'd6)  / 64'd13),
    fix_t'(((64'd13 << FRAC_BITS) + 64'd7)  / 64'd14),
    fix_t'(((64'd14 << FRAC_BITS) + 64'd7)  / 64'd15),
    fix_t'(((64'd15 << FRAC_BITS) + 64'd8)  / 64'd16),
    fix_t'(((64'd16 << FRAC_BITS) + 64'd8)  / 64'd17),
    fix_t'(((64'd17 << FRAC_BITS) + 64'd9)  / 64'd18),
    fix_t'(((64'd18 << FRAC_BITS) + 64'd9)  / 64'd19),
    fix_t'(((64'd19 << FRAC_BITS) + 64'd10) / 64'd20),
    fix_t'(((64'd20 << FRAC_BITS) + 64'd10) / 64'd21),
    fix_t'(((64'd21 << FRAC_BITS) + 64'd11) / 64'd22),
    fix_t'(((64'd22 << FRAC_BITS) + 64'd11) / 64'd23),
    fix_t'(((64'd23 << FRAC_BITS) + 64'd12) / 64'd24),
    fix_t'(((64'd24 << FRAC_BITS) + 64'd12) / 64'd25),
    fix_t'(((64'd25 << FRAC_BITS) + 64'd13) / 64'd26),
    fix_t'(((64'd26 << FRAC_BITS) + 64'd13) / 64'd27),
    fix_t'(((64'd27 << FRAC_BITS) + 64'd14) / 64'd28),
    fix_t'(((64'd28 << FRAC_BITS) + 64'd14) / 64'd29),
    fix_t'(((64'd29 << FRAC_BITS) + 64'd15) / 64'd30),
    fix_t'(((64'd30 << FRAC_BITS) + 64'd15) / 64'd31),
    fix_t'(((64'd31 << FRAC_BITS) + 64'd16) / 64'd32),
    fix_t'(((64'd32 << FRAC_BITS) + 64'd16) / 64'd33),
    fix_t'(((64'd33 << FRAC_BITS) + 64'd17) / 64'd34),
    fix_t'(((64'd34 << FRAC_BITS) + 64'd17) / 64'd35),
    fix_t'(((64'd35 << FRAC_BITS) + 64'd18) / 64'd36),
    fix_t'(((64'd36 << FRAC_BITS) + 64'd18) / 64'd37),
    fix_t'(((64'd37 << FRAC_BITS) + 64'd19) / 64'd38),
    fix_t'(((64'd38 << FRAC_BITS) + 64'd19) / 64'd39),
    fix_t'(((64'd39 << FRAC_BITS) + 64'd20) / 64'd40),
    fix_t'(((64'd40 << FRAC_BITS) + 64'd20) / 64'd41),
    fix_t'(((64'd41 << FRAC_BITS) + 64'd21) / 64'd42),
    fix_t'(((64'd42 << FRAC_BITS) + 64'd21) / 64'd43),
    fix_t'(((64'd43 << FRAC_BITS) + 64'd22) / 64'd44),
    fix_t'(((64'd44 << FRAC_BITS) + 64'd22) / 64'd45),
    fix_t'(((64'd45 << FRAC_BITS) + 64'd23) / 64'd46),
    fix_t'(((64'd46 << FRAC_BITS) + 64'd23) / 64'd47),
    fix_t'(((64'd47 << FRAC_BITS) + 64'd24) / 64'd48),
    fix_t'(((64'd48 << FRAC_BITS) + 64'd24) / 64'd49),
    fix_t'(((64'd49 << FRAC_BITS) + 64'd25) / 64'd50),
    fix_t'(((64'd50 << FRAC_BITS) + 64'd25) / 64'd51),
    fix_t'(((64'd51 << FRAC_BITS) + 64'd26) / 64'd52),
    fix_t'(((64'd52 << FRAC_BITS) + 64'd26) / 64'd53),
    fix_t'(((64'd53 << FRAC_BITS) + 64'd27) / 64'd54),
    fix_t'(((64'd54 << FRAC_BITS) + 64'd27) / 64'd55),
    fix_t'(((64'd55 << FRAC_BITS) + 64'd28) / 64'd56),
    fix_t'(((64'd56 << FRAC_BITS) + 64'd28) / 64'd57),
    fix_t'(((64'd57 << FRAC_BITS) + 64'd29) / 64'd58),
    fix_t'(((64'd58 << FRAC_BITS) + 64'd29) / 64'd59),
    fix_t'(((64'd59 << FRAC_BITS) + 64'd30) / 64'd60),
    fix_t'(((64'd60 << FRAC_BITS) + 64'd30) / 64'd61),
    fix_t'(((64'd61 << FRAC_BITS) + 64'd31) / 64'd62),
    fix_t'(((64'd62 << FRAC_BITS) + 64'd31) / 64'd63),
    fix_t'(((64'd63 << FRAC_BITS) + 64'd32) / 64'd64)
  };

  function automatic fix_t sat32(input sum_t v);
    fix_t r;
    if (!v[SUM_W-1] && (|v[SUM_W-2:FIX_W-1])) begin
      r = {1'b0, {(FIX_W-1){1'b1}}};
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:FIX_W-1])) begin
      r = {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

  function automatic fix_t clamp_unit(input fix_t x);
    fix_t r;
    if (x > ONE_FIX) begin
      r = ONE_FIX;
    end else if (x < NEG_ONE_FIX) begin
      r = NEG_ONE_FIX;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

>>> hdl/lfr_ctrl.sv
// ----------------------------------------------------------------------------
// lfr_ctrl
// Sequencer for the recurrence: accepts an argument, steps the shared
// multiplier three times per order and emits each value in turn.
// ----------------------------------------------------------------------------
module lfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lfr_pkg::dp_status_t status,
  output lfr_pkg::cmd_t      cmd
);
  import lfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT0,
    ST_EMIT1,
    ST_MUL_A,
    ST_RND_A,
    ST_MUL_B,
    ST_RND_B,
    ST_MUL_T,
    ST_RND_T,
    ST_NEXT,
    ST_EMITN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_EMIT0;
        end
      end
      ST_EMIT0: begin
        if (status.out_free) begin
          cmd       = CMD_EMIT0;
          state_nxt = status.at_last ? ST_IDLE : ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (status.out_free) begin
          cmd       = CMD_EMIT1;
          state_nxt = status.lmax_one ? ST_IDLE : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd       = CMD_MUL_A;
        state_nxt = ST_RND_A;
      end
      ST_RND_A: begin
        cmd       = CMD_RND;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd       = CMD_MUL_B;
        state_nxt = ST_RND_B;
      end
      ST_RND_B: begin
        cmd       = CMD_RND;
        state_nxt = ST_MUL_T;
      end
      ST_MUL_T: begin
        cmd       = CMD_MUL_T;
        state_nxt = ST_RND_T;
      end
      ST_RND_T: begin
        cmd       = CMD_RND;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        cmd       = CMD_NEXT;
        state_nxt = ST_EMITN;
      end
      ST_EMITN: begin
        if (status.out_free) begin
          cmd       = CMD_EMITN;
          state_nxt = status.at_last ? ST_IDLE : ST_MUL_A;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/lfr_datapath.sv
// ----------------------------------------------------------------------------
// lfr_datapath
// Recurrence registers, coefficient table, shared 32x32 multiplier with
// rounding stage, saturation and the result register.
// ----------------------------------------------------------------------------
module lfr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfr_pkg::cmd_t                       cmd,
  output lfr_pkg::dp_status_t                 status,
  input  logic [lfr_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  lfr_pkg::ord_t                       highest_order,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // order [5:0], poly_value [37:6], zero pad [39:38]
  output logic [lfr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import lfr_pkg::*;

  fix_t  x_r;
  fix_t  pcur_r;
  fix_t  pprev_r;
  fix_t  t_r;
  rnd_t  v_r;
  prod_t prod_r;
  rnd_t  rnd_r;
  ord_t  l_r;
  ord_t  lmax_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  fix_t  coef_b;
  fix_t  coef_a;
  fix_t  op_a;
  fix_t  op_b;
  prod_t prod_nxt;
  prod_t rsum;
  sum_t  diff;
  logic  emit;
  fix_t  emit_val;
  ord_t  emit_ord;
  logic  emit_last;

  assign coef_b = COEF_B[l_r];
  assign coef_a = ONE_FIX + coef_b;

  always_comb begin
    unique case (cmd)
      CMD_MUL_B: begin
        op_a = coef_b;
        op_b = pprev_r;
      end
      CMD_MUL_T: begin
        op_a = t_r;
        op_b = pcur_r;
      end
      default: begin
        op_a = coef_a;
        op_b = x_r;
      end
    endcase
  end

  assign prod_nxt = prod_t'(op_a) * prod_t'(op_b);
  assign rsum     = prod_r + ROUND_HALF;
  assign diff     = sum_t'(rnd_r) - sum_t'(v_r);

  always_comb begin
    emit      = 1'b0;
    emit_val  = pcur_r;
    emit_ord  = l_r;
    emit_last = (l_r == lmax_r);
    unique case (cmd)
      CMD_EMIT0: begin
        emit     = 1'b1;
        emit_val = ONE_FIX;
      end
      CMD_EMIT1: begin
        emit      = 1'b1;
        emit_val  = x_r;
        emit_ord  = ord_t'(1);
        emit_last = (lmax_r == ord_t'(1));
      end
      CMD_EMITN: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        x_r     <= clamp_unit(fix_t'(in_tdata[FIX_W-1:0]));
        pprev_r <= ONE_FIX;
        l_r     <= '0;
        lmax_r  <= highest_order;
      end
      CMD_EMIT1: begin
        pcur_r <= x_r;
        l_r    <= ord_t'(1);
      end
      CMD_MUL_A: begin
        prod_r <= prod_nxt;
      end
      CMD_RND: begin
        rnd_r <= rsum[PROD_W-1:FRAC_BITS];
      end
      CMD_MUL_B: begin
        t_r    <= sat32(sum_t'(rnd_r));
        prod_r <= prod_nxt;
      end
      CMD_MUL_T: begin
        v_r    <= rnd_r;
        prod_r <= prod_nxt;
      end
      CMD_NEXT: begin
        pprev_r <= pcur_r;
        pcur_r  <= sat32(diff);
        l_r     <= l_r + ord_t'(1);
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_data_r <= {{(OUT_TDATA_W-FIX_W-ORD_W){1'b0}}, emit_val, emit_ord};
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign status.at_last  = (l_r == lmax_r);
  assign status.lmax_one = (lmax_r == ord_t'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hdl/legendre_forward_recurrence.sv
// output: P_0 is registered in ST_EMIT0 after the argument is loaded, P_1 in ST_EMIT1,
// each higher order in ST_EMITN after ST_MUL_A..ST_NEXT; every emit waits while the output is held
// arguments: a new argument is accepted only in ST_IDLE, after the last order has been emitted
// the single shared 32x32 multiplier is used three times per order
// reset: synchronous active-low rst_n, highest_order returns to 50, no output pending
// ----------------------------------------------------------------------------
// legendre_forward_recurrence
// Legendre values P_0..P_L of a Q2.30 argument by Bonnet's forward recurrence,
// with an APB-style register port for the highest order.
// ----------------------------------------------------------------------------
module legendre_forward_recurrence (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // x_value [31:0]
  input  logic [lfr_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // order [5:0], poly_value [37:6], zero pad [39:38]
  output logic [lfr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [lfr_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [lfr_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [lfr_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import lfr_pkg::*;

  ord_t       highest_order_r;
  cmd_t       cmd;
  dp_status_t status;
  logic       reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (reg_idx_t'(cfg_paddr[CFG_AW-1]) == REG_HIGHEST_ORDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_order_r <= HIGHEST_ORDER_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      highest_order_r <= cfg_pwdata[ORD_W-1:0];
    end
  end

  assign cfg_prdata = reg_hit ? {{(CFG_DW-ORD_W){1'b0}}, highest_order_r} : '0;

  lfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lfr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_tdata      (in_tdata),
    .highest_order (highest_order_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule
